/* hw/rtl/csvs_pkg.sv */
// Shared types and constants for the CSV field splitter.
// Used by csvs_decode, csvs_out_queue and csv_field_splitter.
package csvs_pkg;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    KIND_CHAR      = 1'b0,
    KIND_FIELD_END = 1'b1
  } kind_t;

  typedef struct packed {
    logic in_quoted;
    logic escape_armed;
    logic quote_pending;
  } flags_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_value;
    logic       line_end;
    logic       last;
  } result_t;

  // Up to two result words per input byte, plus the updated parser flags.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
    flags_t     flags_nxt;
  } dec_t;

endpackage

/* hw/rtl/csvs_decode.sv */
// Per-byte tokenizer decision: turns one byte and the parser flags into
// up to two result words and the next flags. Depends on csvs_pkg.
module csvs_decode (
  input  logic [7:0]      data_byte,
  input  logic            line_last,
  input  csvs_pkg::flags_t flags,
  output csvs_pkg::dec_t   dec
);

  csvs_pkg::flags_t  f;
  csvs_pkg::result_t first;
  csvs_pkg::result_t fend;
  logic              has_first;
  logic              done;

  always_comb begin
    f         = flags;
    done      = 1'b0;
    has_first = 1'b0;
    first     = '{kind: csvs_pkg::KIND_CHAR, char_value: data_byte, line_end: 1'b0,
                  last: 1'b0};
    fend      = '{kind: csvs_pkg::KIND_FIELD_END, char_value: 8'd0, line_end: 1'b1,
                  last: 1'b1};

    // A quote seen inside quotes is settled by the byte after it.
    if (f.quote_pending) begin
      f.quote_pending = 1'b0;
      if (data_byte == csvs_pkg::CH_QUOTE) begin
        has_first        = 1'b1;
        first.char_value = csvs_pkg::CH_QUOTE;
        done             = 1'b1;
      end else begin
        f.in_quoted = 1'b0;
      end
    end

    if (!done) begin
      if (f.escape_armed) begin
        f.escape_armed = 1'b0;
        has_first      = 1'b1;
      end else if (data_byte == csvs_pkg::CH_BSLASH) begin
        f.escape_armed = 1'b1;
      end else if (data_byte == csvs_pkg::CH_QUOTE) begin
        if (f.in_quoted && !line_last) begin
          f.quote_pending = 1'b1;
        end else begin
          f.in_quoted = ~f.in_quoted;
        end
      end else if (data_byte == csvs_pkg::CH_COMMA && !f.in_quoted) begin
        has_first        = 1'b1;
        first.kind       = csvs_pkg::KIND_FIELD_END;
        first.char_value = 8'd0;
      end else begin
        has_first = 1'b1;
      end
    end

    if (line_last) begin
      f = '0;
    end

    first.last    = has_first && !line_last;
    dec.flags_nxt = f;
    dec.count     = {1'b0, has_first} + {1'b0, line_last};
    dec.r0        = has_first ? first : fend;
    dec.r1        = fend;
  end

endmodule

/* hw/rtl/csvs_out_queue.sv */
// Small result queue that takes up to two words per cycle and hands out one when not stalled.
// Depends on csvs_pkg for the result word type.
module csvs_out_queue #(
  parameter int Depth = csvs_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        push_count,
  input  csvs_pkg::result_t push_r0,
  input  csvs_pkg::result_t push_r1,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_stall,
  output csvs_pkg::result_t out_word
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);

  csvs_pkg::result_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            pop;

  assign out_valid = (count_r != '0);
  assign out_word  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign room2     = (count_r <= CntW'(Depth - 2));
  assign wr_ptr_p1 = (wr_ptr_r == PtrMax) ? '0 : wr_ptr_r + 1'b1;

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrMax) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case (push_count)
      2'd0:    wr_ptr_nxt = wr_ptr_r;
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      default: wr_ptr_nxt = (wr_ptr_p1 == PtrMax) ? '0 : wr_ptr_p1 + 1'b1;
    endcase
    count_nxt = count_r + CntW'(push_count) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem_r[wr_ptr_r] <= push_r0;
    end
    if (push_count == 2'd2) begin
      mem_r[wr_ptr_p1] <= push_r1;
    end
  end

endmodule

/* hw/rtl/csv_field_splitter.sv */
// CSV field splitter: one line byte in per word, field characters and
// field-end markers out. An accepted byte is registered in the input stage; its
// results go into the result queue once that has room for two words. Throughput
// is one byte per cycle while the queue has room for two words; a byte giving
// two results (a trailing comma or a character on the line's last byte) puts
// out two words, limited by the single-word output port behind a 4-entry queue.
// Synchronous active-low reset clears the parser flags, input stage and queue.
module csv_field_splitter #(
  parameter int QueueDepth = csvs_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_line_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_char_value,
  output logic       out_line_end,
  output logic       out_last
);

  logic              stg_valid_r;
  logic [7:0]        stg_byte_r;
  logic              stg_last_r;
  csvs_pkg::flags_t  flags_r;
  csvs_pkg::dec_t    dec;
  csvs_pkg::result_t out_word;
  logic              room2;
  logic              move;
  logic              accept;

  csvs_decode u_decode (
    .data_byte (stg_byte_r),
    .line_last (stg_last_r),
    .flags     (flags_r),
    .dec       (dec)
  );

  // The staged byte moves on only when the queue can take both of its results.
  assign move     = stg_valid_r && room2;
  assign in_stall = stg_valid_r && !room2;
  assign accept   = in_valid && !in_stall;

  csvs_out_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_count (move ? dec.count : 2'd0),
    .push_r0    (dec.r0),
    .push_r1    (dec.r1),
    .room2      (room2),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (accept) begin
        stg_valid_r <= 1'b1;
      end else if (move) begin
        stg_valid_r <= 1'b0;
      end
      if (move) begin
        flags_r <= dec.flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_byte_r <= in_data_byte;
      stg_last_r <= in_line_last;
    end
  end

  assign out_kind       = out_word.kind;
  assign out_char_value = out_word.char_value;
  assign out_line_end   = out_word.line_end;
  assign out_last       = out_word.last;

endmodule

/* hw/rtl/csvs_checker.sv */
// Port-level checks for csv_field_splitter, attached with a bind.
// Sees only the top level's ports.
module csvs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_data_byte,
  input logic       in_line_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_kind,
  input logic [7:0] out_char_value,
  input logic       out_line_end,
  input logic       out_last
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_char_value) && $stable(out_line_end) && $stable(out_last))
    else $error("result word changed while stalled");

  a_char_no_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> !out_line_end)
    else $error("character word flagged as line end");

  a_end_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_char_value == 8'd0)
    else $error("field end carries a character");

  // Closing the line is always the final word of its byte.
  a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_end |-> out_kind && out_last)
    else $error("line end not the final field end");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("results present after reset");

endmodule

bind csv_field_splitter csvs_checker u_csvs_checker (.*);
